/* sv/b2da_pkg.sv */
// Shared types and constants for the binary to decimal ASCII converter.
package b2da_pkg;

	localparam int unsigned BIN_W      = 32;
	localparam int unsigned NUM_DIGITS = 10;
	localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
	localparam int unsigned STEP_W     = $clog2(BIN_W);
	localparam int unsigned NDIG_W     = $clog2(NUM_DIGITS + 1);
	localparam int unsigned CHAR_W     = 6;
	localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;    // capture a new number, clear digits
		logic dabble;  // one shift-and-add-3 conversion step
		logic shift;   // drop the leading digit
	} b2da_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic step_last;  // final conversion step in progress
		logic top_zero;   // leading digit is zero
		logic ndig_one;   // one digit left
	} b2da_stat_t;

endpackage

/* sv/b2da_dp.sv */
// Datapath: binary shift register, BCD digit register, step and digit counters.
module b2da_dp
	import b2da_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  b2da_cmd_t         cmd,
	input  logic [BIN_W-1:0]  value,
	output b2da_stat_t        stat,
	output logic [CHAR_W-1:0] digit_char,
	output logic              last_digit
);

	logic [BIN_W-1:0]  bin_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [BCD_W-1:0]  bcd_adj;
	logic [STEP_W-1:0] step_q;
	logic [NDIG_W-1:0] ndig_q;

	// Add 3 to every digit of 5 or more ahead of the shift
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// Step counter and remaining digit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			ndig_q <= NDIG_W'(NUM_DIGITS);
		end else if (cmd.load) begin
			step_q <= '0;
			ndig_q <= NDIG_W'(NUM_DIGITS);
		end else begin
			if (cmd.dabble) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.shift) begin
				ndig_q <= ndig_q - 1'b1;
			end
		end
	end

	// Number and digit registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (cmd.dabble) begin
			bin_q <= {bin_q[BIN_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[BIN_W-1]};
		end else if (cmd.shift) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
		end
	end

	assign stat.step_last = (step_q == {STEP_W{1'b1}});
	assign stat.top_zero  = (bcd_q[BCD_W-1 -: 4] == 4'd0);
	assign stat.ndig_one  = (ndig_q == NDIG_W'(1));

	assign digit_char = ASCII_ZERO + CHAR_W'(bcd_q[BCD_W-1 -: 4]);
	assign last_digit = stat.ndig_one;

endmodule

/* sv/b2da_ctrl.sv */
// Controller: sequences conversion, leading zero skip and digit output.
module b2da_ctrl
	import b2da_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  b2da_stat_t stat,
	output b2da_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_SKIP = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// Next state and datapath commands
	always_comb begin
		state_nxt  = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.dabble = 1'b1;
				if (stat.step_last) begin
					state_nxt = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (stat.top_zero && !stat.ndig_one) begin
					cmd.shift = 1'b1;
				end else begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (stat.ndig_one) begin
						state_nxt = ST_IDLE;
					end else begin
						cmd.shift = 1'b1;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// A new request is never taken while digits are pending
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("request taken while digits pending");

	// An accepted request starts the conversion
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_CONV))
		else $error("conversion did not start");

	// The final digit ends the run
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && stat.ndig_one) |=> (in_ready && !out_valid))
		else $error("run did not end after last digit");

	// Leading zero skip never shifts out the final digit
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.shift && !out_valid) |-> (stat.top_zero && !stat.ndig_one))
		else $error("bad leading zero skip");

endmodule

/* sv/binary_to_decimal_ascii.sv */
// Sequence: accept, 32 steps of shift-and-add-3, one shift per suppressed leading zero
// and a skip exit, then one digit per cycle while out_ready is high; 1 to 10 digits per
// request. A new number is taken only after the last digit of the previous one is taken.
// Reset: arst_n clears the controller to idle; digit registers need no reset.
module binary_to_decimal_ascii
	import b2da_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BIN_W-1:0]  value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAR_W-1:0] digit_char,
	output logic              last_digit
);

	b2da_cmd_t  cmd;
	b2da_stat_t stat;

	b2da_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	b2da_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.value      (value),
		.stat       (stat),
		.digit_char (digit_char),
		.last_digit (last_digit)
	);

endmodule
